// ===== sv/avcx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the AVI video chunk extractor.
// No dependencies; avcx_parse and the core module import this package.
package avcx_pkg;

	typedef enum logic [3:0] {
		PH_RIFF_HDR  = 4'd0,
		PH_FORM      = 4'd1,
		PH_TOP_HDR   = 4'd2,
		PH_LIST_TYPE = 4'd3,
		PH_TOP_SKIP  = 4'd4,
		PH_MOVI_HDR  = 4'd5,
		PH_MOVI_SKIP = 4'd6,
		PH_FRAME     = 4'd7,
		PH_DONE      = 4'd8
	} phase_t;

	localparam logic [2:0] KIND_PAYLOAD     = 3'd0;
	localparam logic [2:0] KIND_EMPTY_FRAME = 3'd1;
	localparam logic [2:0] KIND_NOT_RIFF    = 3'd2;
	localparam logic [2:0] KIND_NOT_AVI     = 3'd3;
	localparam logic [2:0] KIND_NO_MOVI     = 3'd4;

	// Four-character codes, first file byte in bits 7:0.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;
	localparam logic [31:0] TAG_00DC = 32'h6364_3030;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
		logic       file_end;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] frame_byte;
		logic       frame_last;
	} res_t;

endpackage

// ===== sv/avcx_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input bytes and the results.
// Depends on nothing; the payload fields follow the block's item layout.
interface avcx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	logic       file_end;

	modport source (output valid, data_byte, file_start, file_end, input ready);
	modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface avcx_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, kind, frame_byte, frame_last, input ready);
	modport sink (input valid, kind, frame_byte, frame_last, output ready);
endinterface

// ===== sv/avcx_parse.sv =====
`timescale 1ns / 1ps
// RIFF/AVI parse state and its one-byte update step.
// Depends on avcx_pkg for the phase encoding, tags and item/result types.
module avcx_parse
	import avcx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  item_t       item,
	input  logic [31:0] video_tag,
	output logic        has_res,
	output res_t        res
);

	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [31:0] tag_q;
	logic [31:0] size_q;
	logic [31:0] chunk_q;
	logic [31:0] movi_q;
	logic        pad_q;

	phase_t      ph;
	logic [2:0]  idx;
	logic [31:0] tag;
	logic [31:0] size;
	logic [31:0] chunk;
	logic [31:0] movi;
	logic        pad;
	logic        hdr_done;
	logic [31:0] list_len;

	always_comb begin
		ph       = phase_q;
		idx      = idx_q;
		tag      = tag_q;
		size     = size_q;
		chunk    = chunk_q;
		movi     = movi_q;
		pad      = pad_q;
		hdr_done = 1'b0;
		list_len = '0;
		has_res  = 1'b0;
		res      = '0;

		if (item.file_start) begin
			ph    = PH_RIFF_HDR;
			idx   = '0;
			tag   = '0;
			size  = '0;
			chunk = '0;
			movi  = '0;
			pad   = 1'b0;
		end

		// Header and type bytes shift in from the top, so the first byte lands in bits 7:0.
		case (ph)
			PH_RIFF_HDR, PH_TOP_HDR, PH_MOVI_HDR: begin
				if (idx < 3'd4) begin
					tag = {item.data_byte, tag[31:8]};
				end else begin
					size = {item.data_byte, size[31:8]};
				end
				idx      = idx + 3'd1;
				hdr_done = (idx == 3'd0);
			end
			PH_FORM, PH_LIST_TYPE: begin
				tag = {item.data_byte, tag[31:8]};
				idx = idx + 3'd1;
				if (idx >= 3'd4) begin
					idx      = '0;
					hdr_done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Every byte inside the movi list counts against its budget.
		if (ph inside {PH_MOVI_HDR, PH_MOVI_SKIP, PH_FRAME}) begin
			if (movi != '0) begin
				movi = movi - 32'd1;
			end
		end

		case (ph)
			PH_RIFF_HDR: begin
				if (hdr_done) begin
					if (tag != TAG_RIFF) begin
						has_res  = 1'b1;
						res.kind = KIND_NOT_RIFF;
						ph       = PH_DONE;
					end else begin
						ph = PH_FORM;
					end
				end
			end
			PH_FORM: begin
				if (hdr_done) begin
					if (tag != TAG_AVI) begin
						has_res  = 1'b1;
						res.kind = KIND_NOT_AVI;
						ph       = PH_DONE;
					end else begin
						ph = PH_TOP_HDR;
					end
				end
			end
			PH_TOP_HDR: begin
				if (hdr_done) begin
					if (tag == TAG_LIST) begin
						ph = PH_LIST_TYPE;
					end else begin
						chunk = size;
						pad   = size[0];
						ph    = (size == '0) ? PH_TOP_HDR : PH_TOP_SKIP;
					end
				end
			end
			PH_LIST_TYPE: begin
				if (hdr_done) begin
					list_len = (size >= 32'd4) ? size - 32'd4 : '0;
					if (tag == TAG_MOVI) begin
						movi = list_len;
						ph   = (list_len != '0) ? PH_MOVI_HDR : PH_DONE;
					end else begin
						chunk = list_len;
						pad   = size[0];
						ph    = (list_len == '0 && !size[0]) ? PH_TOP_HDR : PH_TOP_SKIP;
					end
				end
			end
			PH_TOP_SKIP, PH_MOVI_SKIP: begin
				if (chunk != '0) begin
					chunk = chunk - 32'd1;
				end else begin
					pad = 1'b0;
				end
				if (chunk == '0 && !pad) begin
					if (ph == PH_TOP_SKIP) begin
						ph = PH_TOP_HDR;
					end else begin
						ph = (movi != '0) ? PH_MOVI_HDR : PH_DONE;
					end
				end
			end
			PH_MOVI_HDR: begin
				if (hdr_done) begin
					chunk = size;
					pad   = size[0];
					if (tag == video_tag) begin
						if (size == '0) begin
							has_res        = 1'b1;
							res.kind       = KIND_EMPTY_FRAME;
							res.frame_last = 1'b1;
							ph             = (movi != '0) ? PH_MOVI_HDR : PH_DONE;
						end else begin
							ph = PH_FRAME;
						end
					end else if (size == '0) begin
						ph = (movi != '0) ? PH_MOVI_HDR : PH_DONE;
					end else begin
						ph = PH_MOVI_SKIP;
					end
				end
			end
			PH_FRAME: begin
				if (chunk != '0) begin
					chunk = chunk - 32'd1;
				end
				has_res        = 1'b1;
				res.kind       = KIND_PAYLOAD;
				res.frame_byte = item.data_byte;
				res.frame_last = (chunk == '0);
				if (chunk == '0) begin
					if (pad) begin
						ph = PH_MOVI_SKIP;
					end else begin
						ph = (movi != '0) ? PH_MOVI_HDR : PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase

		// An early end of file reports where the header walk stopped, unless a result is out.
		if (item.file_end) begin
			if (!has_res) begin
				if (ph == PH_RIFF_HDR) begin
					has_res  = 1'b1;
					res.kind = KIND_NOT_RIFF;
				end else if (ph == PH_FORM) begin
					has_res  = 1'b1;
					res.kind = KIND_NOT_AVI;
				end else if (ph inside {PH_TOP_HDR, PH_LIST_TYPE, PH_TOP_SKIP}) begin
					has_res  = 1'b1;
					res.kind = KIND_NO_MOVI;
				end
			end
			ph = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF_HDR;
			idx_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			chunk_q <= '0;
			movi_q  <= '0;
			pad_q   <= 1'b0;
		end else if (step) begin
			phase_q <= ph;
			idx_q   <= idx;
			tag_q   <= tag;
			size_q  <= size;
			chunk_q <= chunk;
			movi_q  <= movi;
			pad_q   <= pad;
		end
	end

endmodule

// ===== sv/avi_video_chunk_extractor_core.sv =====
`timescale 1ns / 1ps
// AVI video chunk extractor: walks a RIFF/AVI byte stream and passes on video frame bytes.
// Depends on avcx_pkg, the channel interfaces in avcx_if.sv and avcx_parse.
//
// Usage:
//   item carries one file byte per request with file_start and file_end marks.
//   result carries at most one result per byte: a frame payload byte (with a
//   last-byte mark), an empty frame, or a one-time format error.
//   video_tag_we/video_tag_wdata set the frame chunk tag; write only while idle.
// Timing:
//   An accepted byte is held in the input register; its result is then taken
//   into the result register, so a result passes through both registers.
//   One byte per cycle is sustained unless a byte with a result waits on a held result; the per-byte
//   parse update, 32-bit decrements and compares, is done between those two registers.
// Reset and stalls:
//   Reset returns the parser to the RIFF header and video_tag to "00dc".
//   When the receiver stalls, a byte that gives a result waits in the input
//   register; bytes that give none keep flowing while a result is held.
module avi_video_chunk_extractor_core
	import avcx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	avcx_in_if.sink     item,
	avcx_out_if.source  result,
	input  logic        video_tag_we,
	input  logic [31:0] video_tag_wdata
);

	logic [31:0] video_tag_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        has_res;
	res_t        res;
	logic        advance;
	logic        out_valid_q;
	res_t        out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_tag_q <= TAG_00DC;
		end else if (video_tag_we) begin
			video_tag_q <= video_tag_wdata;
		end
	end

	// A byte moves on unless it has a result and the result register is still held.
	assign advance    = valid_s1 && (!has_res || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.data_byte  <= item.data_byte;
			item_s1.file_start <= item.file_start;
			item_s1.file_end   <= item.file_end;
		end
	end

	avcx_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.video_tag (video_tag_q),
		.has_res   (has_res),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = out_q.kind;
	assign result.frame_byte = out_q.frame_byte;
	assign result.frame_last = out_q.frame_last;

endmodule
